[rtl/sign_magnitude_alu_assert.svh]
// ----------------------------------------------------------------------------
// Sign-magnitude ALU assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef SIGN_MAGNITUDE_ALU_ASSERT_SVH
`define SIGN_MAGNITUDE_ALU_ASSERT_SVH

// Same-cycle implication under reset.
`define SMA_ASSERT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sma check failed");

// Next-cycle implication under reset.
`define SMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sma check failed");

`endif

[rtl/sma_pkg.sv]
// ----------------------------------------------------------------------------
// Sign-magnitude ALU package
// Operation codes, widths and the item record carried along the cell chain.
// ----------------------------------------------------------------------------
package sma_pkg;

	localparam int MAG_W  = 64;
	localparam int OP_W   = 3;
	localparam int NCELLS = MAG_W;

	localparam logic [OP_W-1:0] OP_ADD = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL = 3'd2;
	localparam logic [OP_W-1:0] OP_DIV = 3'd3;
	localparam logic [OP_W-1:0] OP_REM = 3'd4;

	// k: multiplicand or divisor; hi: partial product or remainder;
	// lo: multiplier bits / product low, or dividend / quotient, or add result
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic             a_sign;
		logic             b_sign;
		logic             ovf;
		logic [MAG_W-1:0] k;
		logic [MAG_W-1:0] hi;
		logic [MAG_W-1:0] lo;
	} item_t;

endpackage

[rtl/sma_cell.sv]
// ----------------------------------------------------------------------------
// Sign-magnitude ALU cell
// One shift-add multiply step or one restoring divide step, registered.
// ----------------------------------------------------------------------------
module sma_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid_in,
	input  sma_pkg::item_t item_in,
	output logic           valid_out,
	output sma_pkg::item_t item_out
);

	logic [sma_pkg::MAG_W:0]   sum;
	logic [sma_pkg::MAG_W:0]   rem_t;
	logic [sma_pkg::MAG_W:0]   diff;
	logic                      ge;
	sma_pkg::item_t            nxt;
	logic                      valid_q;
	sma_pkg::item_t            item_q;

	always_comb begin
		sum   = {1'b0, item_in.hi} + (item_in.lo[0] ? {1'b0, item_in.k} : '0);
		rem_t = {item_in.hi, item_in.lo[sma_pkg::MAG_W-1]};
		diff  = rem_t - {1'b0, item_in.k};
		ge    = ~diff[sma_pkg::MAG_W];
		nxt   = item_in;
		if (item_in.op == sma_pkg::OP_MUL) begin
			nxt.hi = sum[sma_pkg::MAG_W:1];
			nxt.lo = {sum[0], item_in.lo[sma_pkg::MAG_W-1:1]};
		end else if (item_in.op == sma_pkg::OP_DIV || item_in.op == sma_pkg::OP_REM) begin
			nxt.hi = ge ? diff[sma_pkg::MAG_W-1:0] : rem_t[sma_pkg::MAG_W-1:0];
			nxt.lo = {item_in.lo[sma_pkg::MAG_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q <= nxt;
		end
	end

	assign valid_out = valid_q;
	assign item_out  = item_q;

endmodule

[rtl/sign_magnitude_alu.sv]
// ----------------------------------------------------------------------------
// Sign-magnitude ALU
// Pipelined 64-bit sign-magnitude add, subtract, multiply, divide, remainder.
// ----------------------------------------------------------------------------
// Takes one item every cycle while the output is not stalled, through an
// add/subtract stage, a chain of 64 cells that each resolve one multiplier
// bit or one quotient bit, and an output register. The whole chain holds
// while a result waits stalled at the output.
module sign_magnitude_alu (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sma_pkg::OP_W-1:0]      operation,
	input  logic                          a_sign,
	input  logic [sma_pkg::MAG_W-1:0]     a_mag,
	input  logic                          b_sign,
	input  logic [sma_pkg::MAG_W-1:0]     b_mag,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          r_sign,
	output logic [sma_pkg::MAG_W-1:0]     r_mag,
	output logic                          overflow,
	output logic                          div_by_zero
);

	logic                       advance;
	logic                       eff_bs;
	logic [sma_pkg::MAG_W:0]    add_sum;
	logic [sma_pkg::MAG_W:0]    add_dif;
	sma_pkg::item_t             front;
	logic                       valid_s1;
	sma_pkg::item_t             item_s1;
	logic                       cv [sma_pkg::NCELLS+1];
	sma_pkg::item_t             ci [sma_pkg::NCELLS+1];
	sma_pkg::item_t             last;
	logic                       res_sign;
	logic [sma_pkg::MAG_W-1:0]  res_mag;
	logic                       res_ovf;
	logic                       res_dz;
	logic                       out_valid_q;
	logic                       r_sign_q;
	logic [sma_pkg::MAG_W-1:0]  r_mag_q;
	logic                       overflow_q;
	logic                       div_by_zero_q;

	assign advance  = ~out_valid_q | ~out_stall;
	assign in_stall = ~advance;

	// front stage: finish add/subtract, load multiply/divide operands
	always_comb begin
		eff_bs       = b_sign ^ (operation == sma_pkg::OP_SUB);
		add_sum      = {1'b0, a_mag} + {1'b0, b_mag};
		add_dif      = {1'b0, a_mag} - {1'b0, b_mag};
		front        = '0;
		front.op     = operation;
		front.a_sign = a_sign;
		front.b_sign = b_sign;
		unique case (operation)
			sma_pkg::OP_ADD, sma_pkg::OP_SUB: begin
				front.b_sign = 1'b0;
				if (a_sign == eff_bs) begin
					front.lo  = add_sum[sma_pkg::MAG_W-1:0];
					front.ovf = add_sum[sma_pkg::MAG_W];
				end else if (!add_dif[sma_pkg::MAG_W]) begin
					front.lo = add_dif[sma_pkg::MAG_W-1:0];
				end else begin
					front.lo     = b_mag - a_mag;
					front.a_sign = eff_bs;
				end
			end
			sma_pkg::OP_MUL: begin
				front.k  = a_mag;
				front.lo = b_mag;
			end
			sma_pkg::OP_DIV, sma_pkg::OP_REM: begin
				front.k  = b_mag;
				front.lo = a_mag;
			end
			default: begin
				front.op = operation;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= front;
		end
	end

	assign cv[0] = valid_s1;
	assign ci[0] = item_s1;

	for (genvar g = 0; g < sma_pkg::NCELLS; g++) begin : g_cell
		sma_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (advance),
			.valid_in  (cv[g]),
			.item_in   (ci[g]),
			.valid_out (cv[g+1]),
			.item_out  (ci[g+1])
		);
	end

	assign last = ci[sma_pkg::NCELLS];

	always_comb begin
		res_sign = 1'b0;
		res_mag  = '0;
		res_ovf  = 1'b0;
		res_dz   = 1'b0;
		unique case (last.op)
			sma_pkg::OP_ADD, sma_pkg::OP_SUB: begin
				res_sign = last.a_sign;
				res_mag  = last.lo;
				res_ovf  = last.ovf;
			end
			sma_pkg::OP_MUL: begin
				res_sign = last.a_sign ^ last.b_sign;
				res_mag  = last.lo;
				res_ovf  = |last.hi;
			end
			sma_pkg::OP_DIV, sma_pkg::OP_REM: begin
				res_dz   = ~|last.k;
				res_sign = last.a_sign ^ last.b_sign;
				if (!res_dz) begin
					res_mag = (last.op == sma_pkg::OP_DIV) ? last.lo : last.hi;
				end
			end
			default: begin
				res_mag = '0;
			end
		endcase
		if (res_mag == '0) begin
			res_sign = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= cv[sma_pkg::NCELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			r_sign_q      <= res_sign;
			r_mag_q       <= res_mag;
			overflow_q    <= res_ovf;
			div_by_zero_q <= res_dz;
		end
	end

	assign out_valid   = out_valid_q;
	assign r_sign      = r_sign_q;
	assign r_mag       = r_mag_q;
	assign overflow    = overflow_q;
	assign div_by_zero = div_by_zero_q;

endmodule

[rtl/sma_checker.sv]
// ----------------------------------------------------------------------------
// Sign-magnitude ALU port checker
// Watches the top level ports for result and handshake consistency.
// ----------------------------------------------------------------------------
`include "sign_magnitude_alu_assert.svh"

module sma_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          r_sign,
	input logic [sma_pkg::MAG_W-1:0]     r_mag,
	input logic                          overflow,
	input logic                          div_by_zero
);

	`SMA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(r_mag) && $stable(r_sign))
	`SMA_ASSERT(a_zero_pos, clk, arst_n, out_valid && r_mag == '0, !r_sign)
	`SMA_ASSERT(a_dz_zero, clk, arst_n, out_valid && div_by_zero, r_mag == '0 && !overflow)
	`SMA_ASSERT(a_stall_only_full, clk, arst_n, in_stall, out_valid && out_stall)

endmodule

bind sign_magnitude_alu sma_checker u_sma_checker (.*);

[tb/sv/tb_sign_magnitude_alu.sv]
// ----------------------------------------------------------------------------
// Sign-magnitude ALU testbench
// Drives random and corner-case operations with random idle gaps on both
// handshakes and checks every result against an in-bench arithmetic model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sign_magnitude_alu;

	localparam int N_RANDOM   = 2000;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN      = 80;

	typedef struct packed {
		logic                      sign;
		logic [sma_pkg::MAG_W-1:0] mag;
		logic                      ovf;
		logic                      dz;
	} alu_result_t;

	class alu_scoreboard;
		alu_result_t pending[$];
		int          errors;

		function alu_result_t compute(logic [sma_pkg::OP_W-1:0] op, logic as,
				logic [sma_pkg::MAG_W-1:0] am, logic bs, logic [sma_pkg::MAG_W-1:0] bm);
			alu_result_t r;
			logic [2*sma_pkg::MAG_W-1:0] prod;
			logic [sma_pkg::MAG_W:0] sum;
			logic eb;
			r = '0;
			eb = (op == sma_pkg::OP_SUB) ? ~bs : bs;
			case (op)
				sma_pkg::OP_ADD, sma_pkg::OP_SUB: begin
					if (as == eb) begin
						sum = {1'b0, am} + {1'b0, bm};
						r.mag = sum[sma_pkg::MAG_W-1:0];
						r.ovf = sum[sma_pkg::MAG_W];
						r.sign = as;
					end else if (am >= bm) begin
						r.mag = am - bm;
						r.sign = as;
					end else begin
						r.mag = bm - am;
						r.sign = eb;
					end
				end
				sma_pkg::OP_MUL: begin
					prod = {{sma_pkg::MAG_W{1'b0}}, am} * {{sma_pkg::MAG_W{1'b0}}, bm};
					r.mag = prod[sma_pkg::MAG_W-1:0];
					r.ovf = |prod[2*sma_pkg::MAG_W-1:sma_pkg::MAG_W];
					r.sign = as ^ bs;
				end
				sma_pkg::OP_DIV, sma_pkg::OP_REM: begin
					if (bm == '0) begin
						r.dz = 1'b1;
					end else begin
						r.mag = (op == sma_pkg::OP_DIV) ? am / bm : am % bm;
						r.sign = as ^ bs;
					end
				end
				default: r = '0;
			endcase
			if (r.mag == '0)
				r.sign = 1'b0;
			return r;
		endfunction

		function void note_input(logic [sma_pkg::OP_W-1:0] op, logic as,
				logic [sma_pkg::MAG_W-1:0] am, logic bs, logic [sma_pkg::MAG_W-1:0] bm);
			pending.push_back(compute(op, as, am, bs, bm));
		endfunction

		task report(string what, logic [sma_pkg::MAG_W-1:0] got,
				logic [sma_pkg::MAG_W-1:0] want);
			$display("mismatch %s: got %h want %h", what, got, want);
			errors++;
		endtask

		task check_result(logic s, logic [sma_pkg::MAG_W-1:0] m, logic o, logic d);
			alu_result_t e;
			if (pending.size() == 0) begin
				report("unexpected item", m, '0);
			end else begin
				e = pending.pop_front();
				if (s !== e.sign) report("r_sign", 64'(s), 64'(e.sign));
				if (m !== e.mag) report("r_mag", m, e.mag);
				if (o !== e.ovf) report("overflow", 64'(o), 64'(e.ovf));
				if (d !== e.dz) report("div_by_zero", 64'(d), 64'(e.dz));
			end
		endtask
	endclass

	logic                      clk = 0;
	logic                      arst_n = 0;
	logic                      in_valid = 0;
	logic                      in_stall;
	logic [sma_pkg::OP_W-1:0]  operation = '0;
	logic                      a_sign = 0;
	logic [sma_pkg::MAG_W-1:0] a_mag = '0;
	logic                      b_sign = 0;
	logic [sma_pkg::MAG_W-1:0] b_mag = '0;
	logic                      out_valid;
	logic                      out_stall = 0;
	logic                      r_sign;
	logic [sma_pkg::MAG_W-1:0] r_mag;
	logic                      overflow;
	logic                      div_by_zero;

	alu_scoreboard sb = new();
	int  idle_cycles = 0;
	bit  rx_hold = 0;

	sign_magnitude_alu dut (.*);

	always #2 clk = ~clk;

	function int gap_len();
		if ($urandom_range(0, 99) < 40) return 0;
		if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	function logic [sma_pkg::MAG_W-1:0] rand_mag();
		logic [sma_pkg::MAG_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			2: v = v >> $urandom_range(32, 63);
			3: v = v >> $urandom_range(1, 31);
			4: v = 64'd1 << $urandom_range(0, 63);
			default: ;
		endcase
		return v;
	endfunction

	task send(logic [sma_pkg::OP_W-1:0] op, logic as, logic [sma_pkg::MAG_W-1:0] am,
			logic bs, logic [sma_pkg::MAG_W-1:0] bm);
		int g;
		g = gap_len();
		repeat (g) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		a_sign <= as;
		a_mag <= am;
		b_sign <= bs;
		b_mag <= bm;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(op, as, am, bs, bm);
	endtask

	task send_random();
		logic [sma_pkg::OP_W-1:0] op;
		op = ($urandom_range(0, 19) == 0) ? sma_pkg::OP_W'($urandom_range(5, 7))
			: sma_pkg::OP_W'($urandom_range(0, 4));
		send(op, 1'($urandom_range(0, 1)), rand_mag(), 1'($urandom_range(0, 1)),
			rand_mag());
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(r_sign, r_mag, overflow, div_by_zero);
	end

	always @(posedge clk) begin
		int g;
		if (rx_hold) begin
			g = gap_len();
			if (g == 0) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				rx_hold = 0;
				repeat (g) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
		rx_hold = ($urandom_range(0, 3) == 0);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [sma_pkg::MAG_W-1:0] mx;
		mx = '1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(sma_pkg::OP_ADD, 1'b0, mx, 1'b0, 64'd1);
		send(sma_pkg::OP_ADD, 1'b1, mx, 1'b1, mx);
		send(sma_pkg::OP_ADD, 1'b0, 64'd5, 1'b1, 64'd9);
		send(sma_pkg::OP_ADD, 1'b1, 64'd7, 1'b0, 64'd7);
		send(sma_pkg::OP_SUB, 1'b0, 64'd3, 1'b0, 64'd10);
		send(sma_pkg::OP_SUB, 1'b0, mx, 1'b1, mx);
		send(sma_pkg::OP_SUB, 1'b1, 64'd0, 1'b0, 64'd0);
		send(sma_pkg::OP_MUL, 1'b0, mx, 1'b0, mx);
		send(sma_pkg::OP_MUL, 1'b1, 64'h1_0000_0000, 1'b0, 64'hFFFF_FFFF);
		send(sma_pkg::OP_MUL, 1'b1, 64'h1_0000_0000, 1'b0, 64'h1_0000_0000);
		send(sma_pkg::OP_MUL, 1'b1, 64'd0, 1'b0, mx);
		send(sma_pkg::OP_DIV, 1'b1, mx, 1'b0, 64'd3);
		send(sma_pkg::OP_DIV, 1'b1, 64'd5, 1'b1, 64'd0);
		send(sma_pkg::OP_DIV, 1'b0, 64'd2, 1'b1, mx);
		send(sma_pkg::OP_REM, 1'b1, mx, 1'b0, 64'd10);
		send(sma_pkg::OP_REM, 1'b0, 64'd9, 1'b0, 64'd0);
		send(sma_pkg::OP_REM, 1'b1, 64'd9, 1'b0, 64'd3);
		send(sma_pkg::OP_W'(5), 1'b1, mx, 1'b1, mx);
		send(sma_pkg::OP_W'(6), 1'b0, 64'd1, 1'b0, 64'd1);
		send(sma_pkg::OP_W'(7), 1'b1, mx, 1'b0, 64'd0);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (sb.pending.size() != 0) @(posedge clk);
			end
			send_random();
		end
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
